>>> sv/lodgrid_pkg.sv
// ============================================================================
// lodgrid_pkg
// Shared types, constants and triangle pattern tables for the LOD grid
// triangle index generator.
// ============================================================================
package lodgrid_pkg;

    // Fixed field widths
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned CELL_W    = 4;
    localparam int unsigned VIDX_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;
    // Vertex coordinate: largest cell (15) times largest step (8) plus one step
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned TRI_CNT_W = 3;

    localparam int unsigned GRID_VERTICES_DEF = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOUTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EAST  = 3'd4;

    // Vertex offset from the cell origin along one axis
    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_HALF,
        OFS_STEP
    } ofs_t;

    typedef struct packed {
        ofs_t row;
        ofs_t col;
    } pt_t;

    typedef struct packed {
        pt_t a;
        pt_t b;
        pt_t c;
    } tri_t;

    // Stitch pattern of one half of a cell.
    // Upper-left half: COL_EDGE = west border, ROW_EDGE = north border.
    // Lower-right half: COL_EDGE = east border, ROW_EDGE = south border.
    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_COL_EDGE,
        MODE_ROW_EDGE,
        MODE_CORNER
    } mode_t;

    function automatic logic [1:0] mode_count(mode_t mode);
        logic [1:0] n;
        case (mode)
            MODE_PLAIN:    n = 2'd1;
            MODE_COL_EDGE: n = 2'd2;
            MODE_ROW_EDGE: n = 2'd2;
            MODE_CORNER:   n = 2'd3;
            default:       n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic tri_t mk_tri(ofs_t r0, ofs_t c0, ofs_t r1, ofs_t c1,
                                    ofs_t r2, ofs_t c2);
        tri_t t;
        t.a.row = r0;
        t.a.col = c0;
        t.b.row = r1;
        t.b.col = c1;
        t.c.row = r2;
        t.c.col = c2;
        return t;
    endfunction

    // Triangle sub of the upper-left (lower = 0) or lower-right half
    function automatic tri_t tri_pattern(logic lower, mode_t mode, logic [1:0] sub);
        tri_t t;
        t = lower ? mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_ZERO, OFS_STEP, OFS_STEP)
                  : mk_tri(OFS_ZERO, OFS_ZERO, OFS_STEP, OFS_ZERO, OFS_ZERO, OFS_STEP);
        if (!lower) begin
            case (mode)
                MODE_CORNER:
                begin
                    case (sub)
                        2'd0:    t = mk_tri(OFS_ZERO, OFS_ZERO, OFS_HALF, OFS_ZERO,
                                            OFS_ZERO, OFS_HALF);
                        2'd1:    t = mk_tri(OFS_ZERO, OFS_HALF, OFS_HALF, OFS_ZERO,
                                            OFS_STEP, OFS_ZERO);
                        default: t = mk_tri(OFS_ZERO, OFS_HALF, OFS_STEP, OFS_ZERO,
                                            OFS_ZERO, OFS_STEP);
                    endcase
                end
                MODE_COL_EDGE:
                begin
                    if (sub == 2'd0)
                        t = mk_tri(OFS_ZERO, OFS_ZERO, OFS_HALF, OFS_ZERO,
                                   OFS_ZERO, OFS_STEP);
                    else
                        t = mk_tri(OFS_HALF, OFS_ZERO, OFS_STEP, OFS_ZERO,
                                   OFS_ZERO, OFS_STEP);
                end
                MODE_ROW_EDGE:
                begin
                    if (sub == 2'd0)
                        t = mk_tri(OFS_ZERO, OFS_ZERO, OFS_STEP, OFS_ZERO,
                                   OFS_ZERO, OFS_HALF);
                    else
                        t = mk_tri(OFS_ZERO, OFS_HALF, OFS_STEP, OFS_ZERO,
                                   OFS_ZERO, OFS_STEP);
                end
                default:
                begin
                    t = mk_tri(OFS_ZERO, OFS_ZERO, OFS_STEP, OFS_ZERO, OFS_ZERO, OFS_STEP);
                end
            endcase
        end else begin
            case (mode)
                MODE_CORNER:
                begin
                    case (sub)
                        2'd0:    t = mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_ZERO,
                                            OFS_HALF, OFS_STEP);
                        2'd1:    t = mk_tri(OFS_HALF, OFS_STEP, OFS_STEP, OFS_ZERO,
                                            OFS_STEP, OFS_HALF);
                        default: t = mk_tri(OFS_HALF, OFS_STEP, OFS_STEP, OFS_HALF,
                                            OFS_STEP, OFS_STEP);
                    endcase
                end
                MODE_COL_EDGE:
                begin
                    if (sub == 2'd0)
                        t = mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_ZERO,
                                   OFS_HALF, OFS_STEP);
                    else
                        t = mk_tri(OFS_HALF, OFS_STEP, OFS_STEP, OFS_ZERO,
                                   OFS_STEP, OFS_STEP);
                end
                MODE_ROW_EDGE:
                begin
                    if (sub == 2'd0)
                        t = mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_ZERO,
                                   OFS_STEP, OFS_HALF);
                    else
                        t = mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_HALF,
                                   OFS_STEP, OFS_STEP);
                end
                default:
                begin
                    t = mk_tri(OFS_ZERO, OFS_STEP, OFS_STEP, OFS_ZERO, OFS_STEP, OFS_STEP);
                end
            endcase
        end
        return t;
    endfunction

endpackage

>>> sv/lod_grid_triangle_index_generator_top.sv
// ============================================================================
// lod_grid_triangle_index_generator_top
// Turns one terrain grid cell into its triangle vertex index triples, with
// edge stitching toward finer neighbour tiles.
// ============================================================================
// Each accepted cell item (cell_col, cell_row, in units of the step
// 2^own_level) yields two to six triangle items, one per cycle while
// tri_stall is low, in the order upper-left half first, lower-right half
// second; last_of_cell marks the final triangle of the cell. A cell that
// runs past the grid edge yields nothing and is dropped in the cycle after
// it is accepted. The rate is set by the single triangle output register,
// which takes one triangle per cycle. Cells are held in an input register
// while their triangles are sent out; the next cell is taken in the same
// cycle as the last triangle of the current one, so the output never
// bubbles between cells. An accepted cell passes the cell holding register,
// then the triangle output register, before its first triangle is on
// tri_valid. A border is stitched when the neighbour level is below
// own_level; the south and east borders exist only when the step divides
// the grid evenly. Vertex indices are row*GRID_VERTICES + col, kept to
// 9 bits. Level registers are written through the cfg port (always ready)
// and must only change while no cell is in flight.
module lod_grid_triangle_index_generator_top #(
    parameter int unsigned GRID_VERTICES = lodgrid_pkg::GRID_VERTICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lodgrid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lodgrid_pkg::LEVEL_W-1:0]     cfg_data,

    // Cell item input
    input  logic                                cell_valid,
    output logic                                cell_stall,
    input  logic [lodgrid_pkg::CELL_W-1:0]      cell_col,
    input  logic [lodgrid_pkg::CELL_W-1:0]      cell_row,

    // Triangle item output
    output logic                                tri_valid,
    input  logic                                tri_stall,
    output logic [lodgrid_pkg::VIDX_W-1:0]      vtx_first,
    output logic [lodgrid_pkg::VIDX_W-1:0]      vtx_second,
    output logic [lodgrid_pkg::VIDX_W-1:0]      vtx_third,
    output logic                                last_of_cell
);

    localparam int unsigned COORD_W = lodgrid_pkg::COORD_W;
    localparam int unsigned VIDX_W  = lodgrid_pkg::VIDX_W;
    localparam int unsigned CNT_W   = lodgrid_pkg::TRI_CNT_W;
    localparam int unsigned STEP_W  = lodgrid_pkg::STEP_W;
    localparam int unsigned LEVEL_W = lodgrid_pkg::LEVEL_W;
    localparam int unsigned PROD_W  = 2 * VIDX_W;

    // Last vertex row/column; grid width kept modulo the index width
    localparam logic [COORD_W-1:0] LIM      = COORD_W'(GRID_VERTICES - 1);
    localparam logic [VIDX_W-1:0]  GRID_MOD = VIDX_W'(GRID_VERTICES);

    // ------------------------------------------------------------------------
    // Level registers
    // ------------------------------------------------------------------------
    logic [LEVEL_W-1:0] own_level_reg,   north_level_reg, south_level_reg;
    logic [LEVEL_W-1:0] west_level_reg,  east_level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_level_reg   <= '0;
            north_level_reg <= '0;
            south_level_reg <= '0;
            west_level_reg  <= '0;
            east_level_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lodgrid_pkg::REG_OWN:   own_level_reg   <= cfg_data;
                lodgrid_pkg::REG_NORTH: north_level_reg <= cfg_data;
                lodgrid_pkg::REG_SOUTH: south_level_reg <= cfg_data;
                lodgrid_pkg::REG_WEST:  west_level_reg  <= cfg_data;
                lodgrid_pkg::REG_EAST:  east_level_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Cell decode at accept: origin, step, border classification
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0]  step_in;
    logic [COORD_W-1:0] c_in, r_in, c_end, r_end;
    logic               on_top, on_left, on_bot, on_right, outside;
    lodgrid_pkg::mode_t ul_mode_in, lr_mode_in;

    always_comb
    begin
        step_in  = STEP_W'(1) << own_level_reg;
        c_in     = COORD_W'(cell_col) << own_level_reg;
        r_in     = COORD_W'(cell_row) << own_level_reg;
        c_end    = c_in + COORD_W'(step_in);
        r_end    = r_in + COORD_W'(step_in);
        outside  = (c_end > LIM) || (r_end > LIM);
        on_top   = (r_in == '0)  && (north_level_reg < own_level_reg);
        on_left  = (c_in == '0)  && (west_level_reg  < own_level_reg);
        on_bot   = (r_end == LIM) && (south_level_reg < own_level_reg);
        on_right = (c_end == LIM) && (east_level_reg  < own_level_reg);
        ul_mode_in = lodgrid_pkg::mode_t'({on_top, on_left});
        lr_mode_in = lodgrid_pkg::mode_t'({on_bot, on_right});
    end

    // ------------------------------------------------------------------------
    // Cell holding register and triangle counter
    // ------------------------------------------------------------------------
    logic               cell_valid_reg, cell_valid_next;
    logic               skip_reg;
    logic [COORD_W-1:0] c_reg, r_reg;
    logic [STEP_W-1:0]  step_reg;
    lodgrid_pkg::mode_t ul_mode_reg, lr_mode_reg;
    logic [CNT_W-1:0]   tri_idx_reg, tri_idx_next;

    logic               tri_valid_reg, tri_valid_next;
    logic               out_free, emit, cell_done, cell_accept;
    logic [CNT_W-1:0]   n_upper, n_total;
    logic               is_last, in_lower;
    logic [1:0]         sub;

    always_comb
    begin
        n_upper  = CNT_W'(lodgrid_pkg::mode_count(ul_mode_reg));
        n_total  = n_upper + CNT_W'(lodgrid_pkg::mode_count(lr_mode_reg));
        is_last  = (tri_idx_reg == n_total - CNT_W'(1));
        in_lower = (tri_idx_reg >= n_upper);
        sub      = in_lower ? 2'(tri_idx_reg - n_upper) : 2'(tri_idx_reg);

        out_free    = !tri_valid_reg || !tri_stall;
        emit        = cell_valid_reg && !skip_reg && out_free;
        cell_done   = cell_valid_reg && (skip_reg || (out_free && is_last));
        cell_stall  = cell_valid_reg && !cell_done;
        cell_accept = cell_valid && !cell_stall;

        cell_valid_next = cell_accept ? 1'b1 : (cell_done ? 1'b0 : cell_valid_reg);
        if (cell_accept)
            tri_idx_next = '0;
        else if (emit)
            tri_idx_next = tri_idx_reg + CNT_W'(1);
        else
            tri_idx_next = tri_idx_reg;

        tri_valid_next = emit ? 1'b1 : (out_free ? 1'b0 : tri_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= 1'b0;
            tri_idx_reg    <= '0;
            tri_valid_reg  <= 1'b0;
        end
        else
        begin
            cell_valid_reg <= cell_valid_next;
            tri_idx_reg    <= tri_idx_next;
            tri_valid_reg  <= tri_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            skip_reg    <= outside;
            c_reg       <= c_in;
            r_reg       <= r_in;
            step_reg    <= step_in;
            ul_mode_reg <= ul_mode_in;
            lr_mode_reg <= lr_mode_in;
        end
    end

    // ------------------------------------------------------------------------
    // Triangle vertex indices
    // ------------------------------------------------------------------------
    lodgrid_pkg::tri_t  tri_cur;
    logic [COORD_W-1:0] half_ofs, step_ofs;
    logic [VIDX_W-1:0]  idx_a, idx_b, idx_c;

    function automatic logic [COORD_W-1:0] pick_ofs(lodgrid_pkg::ofs_t o,
                                                    logic [COORD_W-1:0] h,
                                                    logic [COORD_W-1:0] s);
        logic [COORD_W-1:0] v;
        case (o)
            lodgrid_pkg::OFS_ZERO: v = '0;
            lodgrid_pkg::OFS_HALF: v = h;
            lodgrid_pkg::OFS_STEP: v = s;
            default:               v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VIDX_W-1:0] vidx(lodgrid_pkg::pt_t p,
                                               logic [COORD_W-1:0] r0,
                                               logic [COORD_W-1:0] c0,
                                               logic [COORD_W-1:0] h,
                                               logic [COORD_W-1:0] s);
        logic [COORD_W-1:0] row, col;
        logic [PROD_W-1:0]  prod;
        row  = r0 + pick_ofs(p.row, h, s);
        col  = c0 + pick_ofs(p.col, h, s);
        prod = VIDX_W'(row) * GRID_MOD;
        return prod[VIDX_W-1:0] + VIDX_W'(col);
    endfunction

    always_comb
    begin
        step_ofs = COORD_W'(step_reg);
        half_ofs = COORD_W'(step_reg >> 1);
        tri_cur  = lodgrid_pkg::tri_pattern(in_lower, in_lower ? lr_mode_reg : ul_mode_reg,
                                            sub);
        idx_a    = vidx(tri_cur.a, r_reg, c_reg, half_ofs, step_ofs);
        idx_b    = vidx(tri_cur.b, r_reg, c_reg, half_ofs, step_ofs);
        idx_c    = vidx(tri_cur.c, r_reg, c_reg, half_ofs, step_ofs);
    end

    // ------------------------------------------------------------------------
    // Triangle output register
    // ------------------------------------------------------------------------
    logic [VIDX_W-1:0] vtx_first_reg, vtx_second_reg, vtx_third_reg;
    logic              last_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vtx_first_reg  <= idx_a;
            vtx_second_reg <= idx_b;
            vtx_third_reg  <= idx_c;
            last_reg       <= is_last;
        end
    end

    assign tri_valid    = tri_valid_reg;
    assign vtx_first    = vtx_first_reg;
    assign vtx_second   = vtx_second_reg;
    assign vtx_third    = vtx_third_reg;
    assign last_of_cell = last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // triangle counter stays inside the current cell's pattern
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid_reg && !skip_reg) |-> (tri_idx_reg < n_total))
        else $error("triangle index past end of cell pattern");

    // a new cell cannot enter before the current one sent its last triangle
    a_hold_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid_reg && !skip_reg && !is_last) |-> cell_stall)
        else $error("cell accepted while triangles still pending");

    // output valid only rises from an emitted triangle
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tri_valid_reg) |-> $past(emit))
        else $error("triangle output without emit");

    // finishing a cell with nothing new behind it empties the holding register
    a_cell_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_done && !cell_accept) |=> !cell_valid_reg)
        else $error("cell holding register not released");

endmodule

>>> sim/tb_lod_grid_triangle_index_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lod_grid_triangle_index_generator_top
// Self-checking bench for the terrain cell triangulator. A predictor
// rebuilds every triangle of each accepted cell from the level registers.
// A checker compares each triangle item, field by field, with the oldest
// pending one. Directed cells cover the grid extremes, every stitch pattern
// and dropped cells. Random phases then run under fixed and random levels,
// with idling and stalls on both sides; one test adds a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lod_grid_triangle_index_generator_top;

    localparam int unsigned CFG_IDX_W = lodgrid_pkg::CFG_IDX_W;
    localparam int unsigned LEVEL_W   = lodgrid_pkg::LEVEL_W;
    localparam int unsigned CELL_W    = lodgrid_pkg::CELL_W;
    localparam int unsigned VIDX_W    = lodgrid_pkg::VIDX_W;

    localparam int GRID_N           = lodgrid_pkg::GRID_VERTICES_DEF;
    localparam int RESET_CYCLES     = 5;
    localparam int SETTLE_CYCLES    = 8;      // well past the cell-to-triangle latency
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int MAX_REPORTS      = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASE_CELLS      = 28;
    localparam int RANDOM_PHASES    = 6;

    // Index outside the register map: the write must leave all levels alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [VIDX_W-1:0] vtx_a;
        logic [VIDX_W-1:0] vtx_b;
        logic [VIDX_W-1:0] vtx_c;
        logic              is_last;
    } tri_item_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [LEVEL_W-1:0]   cfg_data     = '0;
    logic                 cell_valid   = 1'b0;
    logic                 cell_stall;
    logic [CELL_W-1:0]    cell_col     = '0;
    logic [CELL_W-1:0]    cell_row     = '0;
    logic                 tri_valid;
    logic                 tri_stall    = 1'b0;
    logic [VIDX_W-1:0]    vtx_first;
    logic [VIDX_W-1:0]    vtx_second;
    logic [VIDX_W-1:0]    vtx_third;
    logic                 last_of_cell;

    // Predictor copy of the level registers (reset value is zero)
    logic [LEVEL_W-1:0]   lvl_own      = '0;
    logic [LEVEL_W-1:0]   lvl_north    = '0;
    logic [LEVEL_W-1:0]   lvl_south    = '0;
    logic [LEVEL_W-1:0]   lvl_west     = '0;
    logic [LEVEL_W-1:0]   lvl_east     = '0;

    tri_item_t            pending_tris[$];    // triangles still owed by the DUT
    int                   fail_count   = 0;
    int                   cycle_count  = 0;

    // Idling controls; the last random phase clears both
    bit                   tx_idle_en   = 1'b1;
    bit                   rx_idle_en   = 1'b1;
    bit                   hold_off_req = 1'b0;

    lod_grid_triangle_index_generator_top #(
        .GRID_VERTICES (GRID_N)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .tri_valid    (tri_valid),
        .tri_stall    (tri_stall),
        .vtx_first    (vtx_first),
        .vtx_second   (vtx_second),
        .vtx_third    (vtx_third),
        .last_of_cell (last_of_cell)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Triangle predictor
    // ------------------------------------------------------------------------

    // Vertex index wraps at the 9-bit output width
    function automatic logic [VIDX_W-1:0] vertex_index(int row, int col);
        return VIDX_W'(row * GRID_N + col);
    endfunction

    function automatic tri_item_t make_tri(int r0, int c0, int r1, int c1,
                                           int r2, int c2);
        tri_item_t t;
        t.vtx_a   = vertex_index(r0, c0);
        t.vtx_b   = vertex_index(r1, c1);
        t.vtx_c   = vertex_index(r2, c2);
        t.is_last = 1'b0;
        return t;
    endfunction

    // Queue every triangle of one cell under the current levels
    function automatic void tessellate_cell(logic [CELL_W-1:0] col,
                                            logic [CELL_W-1:0] row);
        int        s;
        int        h;
        int        c;
        int        r;
        int        lim;
        bit        top;
        bit        left;
        bit        bot;
        bit        right;
        tri_item_t cell_tris[$];
        tri_item_t t;

        s   = 1 << lvl_own;
        h   = s >> 1;
        c   = int'(col) * s;
        r   = int'(row) * s;
        lim = GRID_N - 1;

        // Cell past the grid edge: dropped, nothing owed
        if (c + s > lim || r + s > lim)
            return;

        // A border stitches only toward a finer neighbour; south and east
        // need the cell to end exactly on the last vertex
        top   = (r == 0)       && (lvl_north < lvl_own);
        left  = (c == 0)       && (lvl_west  < lvl_own);
        bot   = (r + s == lim) && (lvl_south < lvl_own);
        right = (c + s == lim) && (lvl_east  < lvl_own);

        // upper-left half
        if (top && left)
        begin
            cell_tris.push_back(make_tri(r, c, r + h, c, r, c + h));
            cell_tris.push_back(make_tri(r, c + h, r + h, c, r + s, c));
            cell_tris.push_back(make_tri(r, c + h, r + s, c, r, c + s));
        end
        else if (left)
        begin
            cell_tris.push_back(make_tri(r, c, r + h, c, r, c + s));
            cell_tris.push_back(make_tri(r + h, c, r + s, c, r, c + s));
        end
        else if (top)
        begin
            cell_tris.push_back(make_tri(r, c, r + s, c, r, c + h));
            cell_tris.push_back(make_tri(r, c + h, r + s, c, r, c + s));
        end
        else
        begin
            cell_tris.push_back(make_tri(r, c, r + s, c, r, c + s));
        end

        // lower-right half
        if (right && bot)
        begin
            cell_tris.push_back(make_tri(r, c + s, r + s, c, r + h, c + s));
            cell_tris.push_back(make_tri(r + h, c + s, r + s, c, r + s, c + h));
            cell_tris.push_back(make_tri(r + h, c + s, r + s, c + h, r + s, c + s));
        end
        else if (right)
        begin
            cell_tris.push_back(make_tri(r, c + s, r + s, c, r + h, c + s));
            cell_tris.push_back(make_tri(r + h, c + s, r + s, c, r + s, c + s));
        end
        else if (bot)
        begin
            cell_tris.push_back(make_tri(r, c + s, r + s, c, r + s, c + h));
            cell_tris.push_back(make_tri(r, c + s, r + s, c + h, r + s, c + s));
        end
        else
        begin
            cell_tris.push_back(make_tri(r, c + s, r + s, c, r + s, c + s));
        end

        foreach (cell_tris[i])
        begin
            t         = cell_tris[i];
            t.is_last = (i == cell_tris.size() - 1);
            pending_tris.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Triangle checker: sampled at the edge, so it sees pre-edge values
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, tri_item_t want, tri_item_t got);
        if (fail_count < MAX_REPORTS)
            $display("ERROR @%0t: %s: expected %0d %0d %0d last=%0d, got %0d %0d %0d last=%0d",
                     $time, what, want.vtx_a, want.vtx_b, want.vtx_c, want.is_last,
                     got.vtx_a, got.vtx_b, got.vtx_c, got.is_last);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : tri_checker
        tri_item_t got;
        tri_item_t want;
        if (rst_n && tri_valid && !tri_stall)
        begin
            got = '{vtx_a: vtx_first, vtx_b: vtx_second, vtx_c: vtx_third,
                    is_last: last_of_cell};
            if (pending_tris.size() == 0)
            begin
                report_mismatch("triangle with none pending", '0, got);
            end
            else
            begin
                want = pending_tris.pop_front();
                if (got.vtx_a !== want.vtx_a || got.vtx_b !== want.vtx_b ||
                    got.vtx_c !== want.vtx_c || got.is_last !== want.is_last)
                    report_mismatch("triangle differs", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall generator: random bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : tri_stall_gen
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    stall_left   = HOLD_OFF_CYCLES;
                end
                else if (rx_idle_en && rst_n && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 10);
                end
            end
            if (stall_left > 0)
            begin
                tri_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                tri_stall <= 1'b0;
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Leaves cfg_valid high so back-to-back writes need no lowering
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lodgrid_pkg::REG_OWN:   lvl_own   = val;
            lodgrid_pkg::REG_NORTH: lvl_north = val;
            lodgrid_pkg::REG_SOUTH: lvl_south = val;
            lodgrid_pkg::REG_WEST:  lvl_west  = val;
            lodgrid_pkg::REG_EAST:  lvl_east  = val;
            default:   ;
        endcase
    endtask

    task automatic set_levels(logic [LEVEL_W-1:0] own, logic [LEVEL_W-1:0] north,
                              logic [LEVEL_W-1:0] south, logic [LEVEL_W-1:0] west,
                              logic [LEVEL_W-1:0] east);
        write_reg(lodgrid_pkg::REG_OWN,   own);
        write_reg(lodgrid_pkg::REG_NORTH, north);
        write_reg(lodgrid_pkg::REG_SOUTH, south);
        write_reg(lodgrid_pkg::REG_WEST,  west);
        write_reg(lodgrid_pkg::REG_EAST,  east);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one cell until taken; valid stays up unless a gap is drawn
    task automatic send_cell(logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
        cell_valid <= 1'b1;
        cell_col   <= col;
        cell_row   <= row;
        do
            @(posedge clk);
        while (cell_stall);
        tessellate_cell(col, row);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Wait out every owed triangle, then let a dropped cell clear the pipe
    task automatic drain_cells();
        cell_valid <= 1'b0;
        while (pending_tris.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly in-grid, biased to the border cells
    function automatic logic [CELL_W-1:0] pick_coord(int span);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 1) ? CELL_W'(span - 1) : '0;
        return CELL_W'($urandom_range(0, span - 1));
    endfunction

    task automatic send_random_cell();
        int span;
        span = (GRID_N - 1) >> lvl_own;
        if (span > 16)
            span = 16;
        if (span < 1)
            span = 1;
        if ($urandom_range(0, 9) == 0)
            send_cell(CELL_W'($urandom), CELL_W'($urandom));   // anywhere, may drop
        else
            send_cell(pick_coord(span), pick_coord(span));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset levels: step one, never stitched, whole field range is in grid
    task automatic test_default_levels();
        send_cell(4'd0, 4'd0);
        send_cell(4'd15, 4'd15);
        send_cell(4'd15, 4'd0);
        send_cell(4'd0, 4'd15);
        send_cell(4'd8, 4'd7);
        drain_cells();
    endtask

    task automatic test_stitch_patterns();
        // Step 8, all neighbours finer: corners and mixed borders
        set_levels(2'd3, 2'd0, 2'd0, 2'd0, 2'd0);
        send_cell(4'd0, 4'd0);
        send_cell(4'd1, 4'd0);
        send_cell(4'd0, 4'd1);
        send_cell(4'd1, 4'd1);
        send_cell(4'd2, 4'd0);      // runs past the east edge
        send_cell(4'd15, 4'd15);    // far outside
        drain_cells();

        // Write to an unmapped index must not disturb the levels
        write_reg(REG_UNUSED, 2'd3);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // Step 4, north and west stitched only
        set_levels(2'd2, 2'd1, 2'd2, 2'd0, 2'd3);
        send_cell(4'd0, 4'd0);
        send_cell(4'd3, 4'd0);
        send_cell(4'd0, 4'd3);
        send_cell(4'd3, 4'd3);
        drain_cells();

        // Step 2, south and east stitched only
        set_levels(2'd1, 2'd1, 2'd0, 2'd3, 2'd0);
        send_cell(4'd7, 4'd7);
        send_cell(4'd0, 4'd7);
        send_cell(4'd7, 4'd0);
        send_cell(4'd4, 4'd4);
        drain_cells();
    endtask

    // Output held off while cells keep coming: the input must stall
    task automatic test_input_backpressure();
        set_levels(2'd3, 2'd0, 2'd0, 2'd0, 2'd0);
        tx_idle_en   = 1'b0;
        hold_off_req = 1'b1;
        repeat (20) send_random_cell();
        tx_idle_en   = 1'b1;
        drain_cells();
    endtask

    task automatic test_random_levels();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                set_levels(2'd0, 2'd3, 2'd3, 2'd3, 2'd3);
            else if (phase == 1)
                set_levels(2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
            else
                set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                           LEVEL_W'($urandom), LEVEL_W'($urandom));
            // Last phase runs at full rate on both sides
            if (phase == RANDOM_PHASES - 1)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (PHASE_CELLS) send_random_cell();
            drain_cells();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_levels();
        test_stitch_patterns();
        test_input_backpressure();
        test_random_levels();

        if (fail_count == 0 && pending_tris.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
sv/lodgrid_pkg.sv
sv/lod_grid_triangle_index_generator_top.sv
sim/tb_lod_grid_triangle_index_generator_top.sv
